@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/fcull_pkg.sv @@
`timescale 1ns / 1ps

package fcull_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_SPHERE = 2'd2,
    KIND_CUBE   = 2'd3
  } kind_t;

  localparam int PROD_W   = 48;
  localparam int SPREAD_W = 17;
  localparam int EXT_W    = 48;
  localparam int ACC_W    = 52;
  localparam int FRAC_SH  = 14;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         plane_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        extent;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
    logic               all_pass;
  } item_t;

  function automatic logic [SPREAD_W-1:0] abs16(input logic signed [15:0] a);
    logic signed [16:0] ext;
    ext = {a[15], a};
    return ext[16] ? SPREAD_W'(-ext) : SPREAD_W'(ext);
  endfunction

endpackage

@@ rtl/core/frustum_cull_test.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Six-plane frustum cull. Load transfers (tuser = 0) write at most one clip
// plane; point, sphere and cube queries (tuser = 1, 2, 3) each return one bit,
// 1 when a point or cube lies strictly inside every plane, or a sphere reaches
// strictly inside each. Planes reset to zero. Each plane lives in its own cell
// of a chain. Output back-pressure stalls the whole chain; otherwise an item
// moves one cell stage per cycle, two stages per cell (multiply, then sum and
// compare), so one item is accepted every cycle. Loads travel the same chain,
// so every query sees exactly the planes loaded before it.
module frustum_cull_test import fcull_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // plane_index, pos_x, pos_y, pos_z, extent, normal_x, normal_y, normal_z,
  // plane_offset, zero pad
  input  logic [215:0] s_tdata,
  // kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // inside_res, zero pad
  output logic [7:0]   m_tdata
);

  logic  en;
  logic  chain_valid [0:NUM_PLANES];
  item_t chain_item  [0:NUM_PLANES];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    chain_valid[0]             = s_tvalid;
    chain_item[0].kind         = kind_t'(s_tuser);
    chain_item[0].plane_index  = s_tdata[2:0];
    chain_item[0].pos_x        = s_tdata[34:3];
    chain_item[0].pos_y        = s_tdata[66:35];
    chain_item[0].pos_z        = s_tdata[98:67];
    chain_item[0].extent       = s_tdata[129:99];
    chain_item[0].normal_x     = s_tdata[145:130];
    chain_item[0].normal_y     = s_tdata[161:146];
    chain_item[0].normal_z     = s_tdata[177:162];
    chain_item[0].plane_offset = s_tdata[209:178];
    chain_item[0].all_pass     = 1'b1;
  end

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    fcull_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (chain_valid[i]),
      .in_item  (chain_item[i]),
      .out_valid(chain_valid[i+1]),
      .out_item (chain_item[i+1])
    );
  end

  logic end_query;
  assign end_query = chain_valid[NUM_PLANES] && (chain_item[NUM_PLANES].kind != KIND_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= end_query;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'd0, chain_item[NUM_PLANES].all_pass};
    end
  end

  `ASSERT_ALWAYS(a_idle_after_rst, $past(rst) |-> !m_tvalid,
    "result pending right after reset")
  `ASSERT_CLK(a_load_silent,
    (en && chain_valid[NUM_PLANES] && chain_item[NUM_PLANES].kind == KIND_LOAD)
    |=> !m_tvalid, "load produced a result")
  `ASSERT_CLK(a_query_out, (en && end_query) |=>
    (m_tvalid && m_tdata[0] == $past(chain_item[NUM_PLANES].all_pass)),
    "query result lost")
  `ASSERT_CLK(a_stall_chain, !en |=>
    ($stable(chain_valid[NUM_PLANES]) && $stable(chain_item[NUM_PLANES])),
    "chain moved under stall")

endmodule

@@ rtl/core/fcull_cell.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcull_cell import fcull_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  out_valid,
  output item_t out_item
);

  // stored plane
  logic signed [15:0]  nx, ny, nz;
  logic signed [31:0]  d;
  logic [SPREAD_W-1:0] spread;

  logic load_hit;
  assign load_hit = in_valid && (in_item.kind == KIND_LOAD) &&
                    ({29'd0, in_item.plane_index} == 32'(INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      nx     <= '0;
      ny     <= '0;
      nz     <= '0;
      d      <= '0;
      spread <= '0;
    end else if (en && load_hit) begin
      nx     <= in_item.normal_x;
      ny     <= in_item.normal_y;
      nz     <= in_item.normal_z;
      d      <= in_item.plane_offset;
      spread <= abs16(in_item.normal_x) + abs16(in_item.normal_y) +
                abs16(in_item.normal_z);
    end
  end

  // stage A: products
  logic                     a_valid;
  item_t                    a_item;
  logic signed [PROD_W-1:0] a_px, a_py, a_pz;
  logic signed [31:0]       a_d;
  logic [EXT_W-1:0]         a_ext;
  logic [EXT_W-1:0]         ext_next;

  always_comb begin
    case (in_item.kind)
      KIND_SPHERE: ext_next = EXT_W'({in_item.extent, 14'd0});
      KIND_CUBE:   ext_next = EXT_W'(in_item.extent) * EXT_W'(spread);
      default:     ext_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_item;
      a_px   <= in_item.pos_x * nx;
      a_py   <= in_item.pos_y * ny;
      a_pz   <= in_item.pos_z * nz;
      a_d    <= d;
      a_ext  <= ext_next;
    end
  end

  // stage B: sum and compare
  logic signed [ACC_W-1:0] v, ext_s, d_s, margin;
  logic                    pass;
  item_t                   b_item_next;

  always_comb begin
    d_s    = signed'(ACC_W'(a_d)) <<< FRAC_SH;
    ext_s  = signed'(ACC_W'(a_ext));
    v      = signed'(ACC_W'(a_px)) + signed'(ACC_W'(a_py)) +
             signed'(ACC_W'(a_pz)) + d_s;
    margin = (a_item.kind == KIND_CUBE) ? v - ext_s : v + ext_s;
    pass   = !margin[ACC_W-1] && (margin != '0);
    b_item_next = a_item;
    if (a_item.kind != KIND_LOAD) begin
      b_item_next.all_pass = a_item.all_pass & pass;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= b_item_next;
    end
  end

  `ASSERT_CLK(a_plane_hold, !(en && load_hit) |=>
    ($stable(nx) && $stable(ny) && $stable(nz) && $stable(d)),
    "plane changed without a matching load")
  `ASSERT_CLK(a_spread_sum,
    spread == SPREAD_W'(abs16(nx) + abs16(ny) + abs16(nz)),
    "stored spread out of step with normal")

endmodule

@@ sim/frustum_cull_test_test.sv @@
`timescale 1ns / 1ps

module frustum_cull_test_test;
  import fcull_pkg::*;

  localparam int PLANE_CNT  = 6;
  localparam int RAND_ITEMS = 750;
  localparam int MAX_IDLE   = 14;
  localparam int DRAIN_CYC  = 40;

  typedef struct {
    kind_t              kind;
    logic [2:0]         plane_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        extent;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
  } cull_req_t;

  class cull_scoreboard;
    logic signed [15:0] nrm_x[PLANE_CNT];
    logic signed [15:0] nrm_y[PLANE_CNT];
    logic signed [15:0] nrm_z[PLANE_CNT];
    logic signed [31:0] ofs[PLANE_CNT];
    bit                 inside_q[$];
    int                 errors;

    function new();
      for (int i = 0; i < PLANE_CNT; i++) begin
        nrm_x[i] = '0;
        nrm_y[i] = '0;
        nrm_z[i] = '0;
        ofs[i]   = '0;
      end
      errors = 0;
    endfunction

    // plane loads update the plane set, queries queue the predicted inside bit
    function void note_transfer(cull_req_t r);
      longint v, spread, ext;
      bit     all_in;
      bit     pass;
      if (r.kind == KIND_LOAD) begin
        if (r.plane_index < PLANE_CNT) begin
          nrm_x[r.plane_index] = r.normal_x;
          nrm_y[r.plane_index] = r.normal_y;
          nrm_z[r.plane_index] = r.normal_z;
          ofs[r.plane_index]   = r.plane_offset;
        end
        return;
      end
      ext    = longint'(r.extent);
      all_in = 1'b1;
      for (int i = 0; i < PLANE_CNT; i++) begin
        v = longint'(nrm_x[i]) * longint'(r.pos_x) + longint'(nrm_y[i]) * longint'(r.pos_y)
          + longint'(nrm_z[i]) * longint'(r.pos_z) + longint'(ofs[i]) * 64'sd16384;
        case (r.kind)
          KIND_POINT:  pass = (v > 0);
          KIND_SPHERE: pass = (v > -(ext * 64'sd16384));
          default: begin
            spread = (nrm_x[i] < 0 ? -longint'(nrm_x[i]) : longint'(nrm_x[i]))
                   + (nrm_y[i] < 0 ? -longint'(nrm_y[i]) : longint'(nrm_y[i]))
                   + (nrm_z[i] < 0 ? -longint'(nrm_z[i]) : longint'(nrm_z[i]));
            pass = ((v - ext * spread) > 0);
          end
        endcase
        if (!pass) all_in = 1'b0;
      end
      inside_q.push_back(all_in);
    endfunction

    function void check_result(logic [7:0] data);
      bit want;
      if (inside_q.size() == 0) begin
        $error("unexpected result transfer: inside_res = %0d", data[0]);
        errors++;
        return;
      end
      want = inside_q.pop_front();
      if (data[0] !== want) begin
        $error("inside_res mismatch: expected %0d, actual %0d", want, data[0]);
        errors++;
      end
    endfunction

    function int pending();
      return inside_q.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [215:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [7:0]   m_tdata;

  cull_req_t      drv_req;
  cull_scoreboard sb;
  bit             send_burst;
  bit             recv_burst;
  int             sent;

  frustum_cull_test i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_transfer(drv_req);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  function automatic cull_req_t load_req(int idx, int nx, int ny, int nz, int off);
    cull_req_t r;
    r = '{kind: KIND_LOAD, default: '0};
    r.kind         = KIND_LOAD;
    r.plane_index  = idx[2:0];
    r.normal_x     = nx[15:0];
    r.normal_y     = ny[15:0];
    r.normal_z     = nz[15:0];
    r.plane_offset = off;
    return r;
  endfunction

  function automatic cull_req_t query_req(kind_t k, int px, int py, int pz, int unsigned ext);
    cull_req_t r;
    r = '{kind: KIND_LOAD, default: '0};
    r.kind   = k;
    r.pos_x  = px;
    r.pos_y  = py;
    r.pos_z  = pz;
    r.extent = ext[30:0];
    return r;
  endfunction

  // fields the transfer's kind ignores still carry random bits
  function automatic cull_req_t fill_unused(cull_req_t r);
    if (r.kind == KIND_LOAD) begin
      r.pos_x  = $urandom;
      r.pos_y  = $urandom;
      r.pos_z  = $urandom;
      r.extent = $urandom;
    end else begin
      r.plane_index  = $urandom;
      r.normal_x     = $urandom;
      r.normal_y     = $urandom;
      r.normal_z     = $urandom;
      r.plane_offset = $urandom;
    end
    return r;
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send(cull_req_t r);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {6'b0, r.plane_offset, r.normal_z, r.normal_y, r.normal_x, r.extent,
                 r.pos_z, r.pos_y, r.pos_x, r.plane_index};
    drv_req  <= r;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (!(r.kind == KIND_LOAD && r.plane_index >= PLANE_CNT)) sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    cull_req_t dq[$];
    int b;
    b = 10 << 16;
    // planes still at reset
    dq.push_back(query_req(KIND_POINT, 0, 0, 0, 0));
    dq.push_back(query_req(KIND_SPHERE, 0, 0, 0, 5));
    dq.push_back(query_req(KIND_SPHERE, 0, 0, 0, 0));
    dq.push_back(query_req(KIND_CUBE, 0, 0, 0, 32'h7fff_ffff));
    // out-of-range loads leave the planes untouched
    dq.push_back(load_req(6, 16384, 0, 0, 1 << 20));
    dq.push_back(load_req(7, 32767, 32767, 32767, 32'h7fff_ffff));
    dq.push_back(query_req(KIND_POINT, 0, 0, 0, 0));
    // axis box of +-10.0
    for (int a = 0; a < 3; a++) begin
      dq.push_back(load_req(2 * a, a == 0 ? 16384 : 0, a == 1 ? 16384 : 0,
                            a == 2 ? 16384 : 0, b));
      dq.push_back(load_req(2 * a + 1, a == 0 ? -16384 : 0, a == 1 ? -16384 : 0,
                            a == 2 ? -16384 : 0, b));
    end
    dq.push_back(query_req(KIND_POINT, 0, 0, 0, 0));
    dq.push_back(query_req(KIND_POINT, b, 0, 0, 0));
    dq.push_back(query_req(KIND_POINT, b - 1, 0, -b + 1, 0));
    dq.push_back(query_req(KIND_SPHERE, 11 << 16, 0, 0, (1 << 16) + 1));
    dq.push_back(query_req(KIND_SPHERE, 11 << 16, 0, 0, 1 << 16));
    dq.push_back(query_req(KIND_CUBE, 0, 0, 0, b - 1));
    dq.push_back(query_req(KIND_CUBE, 0, 0, 0, b));
    dq.push_back(query_req(KIND_CUBE, b, 0, 0, 0));
    dq.push_back(query_req(KIND_SPHERE, 0, 0, 0, 0));
    dq.push_back(query_req(KIND_SPHERE, 0, 0, 0, 32'h7fff_ffff));
    dq.push_back(query_req(KIND_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    // extreme plane parts
    dq.push_back(load_req(0, -32768, -32768, -32768, 32'h8000_0000));
    dq.push_back(load_req(5, 32767, 32767, 32767, 32'h7fff_ffff));
    dq.push_back(query_req(KIND_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    dq.push_back(query_req(KIND_SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff));
    dq.push_back(query_req(KIND_CUBE, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff));
    foreach (dq[i]) send(fill_unused(dq[i]));
  endtask

  function automatic int near_coord();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return int'($urandom_range(0, 1 << 22)) - (1 << 21);
  endfunction

  function automatic int unsigned rand_extent();
    case ($urandom_range(0, 19))
      0:       return 0;
      1, 2:    return $urandom_range(0, 32'h7fff_ffff);
      default: return $urandom_range(0, 1 << 19);
    endcase
  endfunction

  function automatic cull_req_t rand_query();
    kind_t k;
    k = kind_t'($urandom_range(1, 3));
    return fill_unused(query_req(k, near_coord(), near_coord(), near_coord(), rand_extent()));
  endfunction

  task automatic load_frame(bit boxed);
    int lo, hi, tilt;
    for (int a = 0; a < 3; a++) begin
      lo   = -int'($urandom_range(1, 1 << 20));
      hi   = $urandom_range(1, 1 << 20);
      tilt = $urandom_range(0, 2) == 0 ? 64 : 0;
      for (int s = 0; s < 2; s++) begin
        if (boxed)
          send(fill_unused(load_req(2 * a + s,
            a == 0 ? (s ? -16384 : 16384) : int'($urandom_range(0, 2 * tilt)) - tilt,
            a == 1 ? (s ? -16384 : 16384) : int'($urandom_range(0, 2 * tilt)) - tilt,
            a == 2 ? (s ? -16384 : 16384) : int'($urandom_range(0, 2 * tilt)) - tilt,
            s ? hi : -lo)));
        else
          send(fill_unused(load_req(2 * a + s, $urandom, $urandom, $urandom, $urandom)));
        if ($urandom_range(0, 15) == 0)
          send(fill_unused(load_req($urandom_range(6, 7), $urandom, $urandom,
                                    $urandom, $urandom)));
      end
    end
  endtask

  task automatic run_random();
    int n_q;
    bit first;
    first = 1'b1;
    while (sent < RAND_ITEMS) begin
      send_burst = ($urandom_range(0, 3) == 0);
      if (first || $urandom_range(0, 7) == 0) wait_drained();
      first = 1'b0;
      load_frame($urandom_range(0, 9) < 7);
      n_q = $urandom_range(10, 40);
      for (int i = 0; i < n_q; i++) begin
        // partial reload while queries are still in flight
        if ($urandom_range(0, 24) == 0)
          send(fill_unused(load_req($urandom_range(0, 7), $urandom, $urandom,
                                    $urandom, $urandom)));
        send(rand_query());
      end
    end
  endtask

  initial begin : rx
    int stall;
    int n;
    n = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (n % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      n++;
      stall = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("** frustum_cull_test: FAILED **");
    $finish;
  end

  initial begin : main
    int fails;
    sb         = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    m_tready   = 1'b0;
    drv_req    = '{kind: KIND_LOAD, default: '0};
    send_burst = 1'b0;
    recv_burst = 1'b0;
    sent       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    sent = 0;
    run_random();
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    fails = sb.errors;
    if (sb.pending() != 0) begin
      $error("%0d inside_res results never arrived", sb.pending());
      fails++;
    end
    if (fails == 0) begin
      $display("** frustum_cull_test: PASSED **");
    end else begin
      $display("** frustum_cull_test: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/fcull_pkg.sv
rtl/core/fcull_cell.sv
rtl/core/frustum_cull_test.sv
sim/frustum_cull_test_test.sv
